FILE: rtl/simp_pkg.sv
package simp_pkg;

    localparam int CNT_W       = 10;
    localparam int SMP_W       = 16;
    localparam int STEP_W      = 16;
    localparam int SIMP_W      = 32;
    localparam int TAIL_W      = 20;
    localparam int TRAP_W      = 18;
    localparam int RES_W       = 48;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int MAX_SAMPLES_DEF = 1000;

    // Weighted sample: up to 4 * sample, with sign.
    localparam int WSMP_W      = SMP_W + 3;

    localparam logic [CNT_W-1:0]  CNT_RESET  = 10'd2;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd51;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_COUNT = 1'b0,
        CFG_STEP_SIZE    = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_TRAP,
        MODE_38,
        MODE_ODD,
        MODE_MIXED
    } t_mode;

    // Sums of one finished integral, handed to the scaling pipeline.
    typedef struct packed {
        logic                     err;
        logic signed [SIMP_W-1:0] simpson;
        logic signed [TAIL_W-1:0] tail;
        logic signed [TRAP_W-1:0] trap;
        logic [STEP_W-1:0]        step;
    } t_snap;

endpackage

FILE: rtl/simp_if.sv
interface simp_in_if import simp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface simp_out_if import simp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] integral;
    logic                    status;

    modport source (output valid, output integral, output status, input ready);
    modport sink   (input valid, input integral, input status, output ready);
endinterface

FILE: rtl/simp_accum.sv
module simp_accum import simp_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_beat,
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic                    i_en,
    output logic                    o_snap_vld,
    output t_snap                   o_snap
);

    logic [CNT_W-1:0]         r_count;
    logic [STEP_W-1:0]        r_step;
    logic [CNT_W-1:0]         r_idx;
    logic signed [SIMP_W-1:0] r_simp;
    logic signed [TAIL_W-1:0] r_tail;
    logic signed [TRAP_W-1:0] r_trap;
    logic                     r_snap_vld;
    t_snap                    r_snap;

    logic signed [SIMP_W-1:0] n_simp;
    logic signed [TAIL_W-1:0] n_tail;
    logic signed [TRAP_W-1:0] n_trap;

    logic             invalid;
    logic             last;
    t_mode            mode;
    logic [CNT_W-1:0] len;
    logic [2:0]       w_simp;
    logic [2:0]       w_tail;

    function automatic logic signed [WSMP_W-1:0] weigh(
        input logic signed [SMP_W-1:0] s,
        input logic [2:0]              w
    );
        logic signed [WSMP_W-1:0] x;
        logic signed [WSMP_W-1:0] r;
        x = WSMP_W'(s);
        case (w)
            3'd1:    r = x;
            3'd2:    r = x <<< 1;
            3'd3:    r = x + (x <<< 1);
            3'd4:    r = x <<< 2;
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb begin
        invalid = (r_count < CNT_W'(2)) || (r_count > CNT_W'(MAX_SAMPLES));
        last    = (r_idx == r_count - CNT_W'(1));

        if (r_count == CNT_W'(2)) begin
            mode = MODE_TRAP;
        end else if (r_count == CNT_W'(4)) begin
            mode = MODE_38;
        end else if (r_count[0]) begin
            mode = MODE_ODD;
        end else begin
            mode = MODE_MIXED;
        end

        // In the mixed rule the Simpson part covers the first count-3 samples.
        len = (mode == MODE_MIXED) ? r_count - CNT_W'(3) : r_count;

        if (r_idx >= len) begin
            w_simp = 3'd0;
        end else if (r_idx == '0 || r_idx == len - CNT_W'(1)) begin
            w_simp = 3'd1;
        end else begin
            w_simp = r_idx[0] ? 3'd4 : 3'd2;
        end

        if (r_idx < r_count - CNT_W'(4)) begin
            w_tail = 3'd0;
        end else if (r_idx == r_count - CNT_W'(4) || r_idx == r_count - CNT_W'(1)) begin
            w_tail = 3'd1;
        end else begin
            w_tail = 3'd3;
        end

        n_simp = r_simp;
        n_tail = r_tail;
        n_trap = r_trap;
        unique case (mode)
            MODE_TRAP: begin
                n_trap = r_trap + TRAP_W'(i_sample);
            end
            MODE_38: begin
                n_tail = r_tail + TAIL_W'(weigh(i_sample, w_tail));
            end
            MODE_ODD: begin
                n_simp = r_simp + SIMP_W'(weigh(i_sample, w_simp));
            end
            MODE_MIXED: begin
                n_simp = r_simp + SIMP_W'(weigh(i_sample, w_simp));
                n_tail = r_tail + TAIL_W'(weigh(i_sample, w_tail));
            end
            default: begin
                n_simp = r_simp;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= CNT_RESET;
            r_step     <= STEP_RESET;
            r_idx      <= '0;
            r_simp     <= '0;
            r_tail     <= '0;
            r_trap     <= '0;
            r_snap_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SAMPLE_COUNT: begin
                        r_count <= i_cfg_data[CNT_W-1:0];
                        r_idx   <= '0;
                        r_simp  <= '0;
                        r_tail  <= '0;
                        r_trap  <= '0;
                    end
                    CFG_STEP_SIZE: begin
                        r_step <= i_cfg_data[STEP_W-1:0];
                    end
                    default: begin
                        r_step <= r_step;
                    end
                endcase
            end else if (i_beat) begin
                if (invalid || last) begin
                    r_idx  <= '0;
                    r_simp <= '0;
                    r_tail <= '0;
                    r_trap <= '0;
                end else begin
                    r_idx  <= r_idx + CNT_W'(1);
                    r_simp <= n_simp;
                    r_tail <= n_tail;
                    r_trap <= n_trap;
                end
            end
            if (i_en) begin
                r_snap_vld <= i_beat && (invalid || last);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_snap.err     <= invalid;
            r_snap.simpson <= n_simp;
            r_snap.tail    <= n_tail;
            r_snap.trap    <= n_trap;
            r_snap.step    <= r_step;
        end
    end

    assign o_snap_vld = r_snap_vld;
    assign o_snap     = r_snap;

endmodule

FILE: rtl/simp_scale.sv
module simp_scale import simp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_snap_vld,
    input  t_snap       i_snap,
    output logic        o_en,
    simp_out_if.source  o_res
);

    localparam int TOT_W = SIMP_W + 4;
    localparam int MAG_W = 32;
    localparam int A_W   = MAG_W - 4;
    localparam int AH_W  = A_W + STEP_W;
    localparam int BH_W  = 5 + STEP_W;
    localparam int Y_W   = BH_W - 3;
    localparam int Q2_W  = Y_W - 1;
    localparam int SUM_W = AH_W + 1;

    localparam logic [MAG_W:0] RECIP3_33 = 33'h0AAAAAAAB;
    localparam logic [Y_W-1:0] RECIP3_19 = 18'h2AAAB;

    logic en;

    // Stage 2: combined sum, as sign and magnitude.
    logic              r2_vld;
    logic              r2_err;
    logic              r2_neg;
    logic [MAG_W-1:0]  r2_mag;
    logic [STEP_W-1:0] r2_step;

    // Stage 3: a = magnitude / 24.
    logic              r3_vld;
    logic              r3_err;
    logic              r3_neg;
    logic [MAG_W-1:0]  r3_mag;
    logic [A_W-1:0]    r3_a;
    logic [STEP_W-1:0] r3_step;

    // Stage 4: a*h and (remainder)*h.
    logic              r4_vld;
    logic              r4_err;
    logic              r4_neg;
    logic [AH_W-1:0]   r4_ah;
    logic [BH_W-1:0]   r4_bh;

    logic                    r_out_vld;
    logic signed [RES_W-1:0] r_integral;
    logic                    r_status;

    logic signed [TOT_W-1:0]   total;
    logic [TOT_W-1:0]          tot_abs;
    logic [2*MAG_W-4:0]        prod_a;
    logic [MAG_W-1:0]          rem;
    logic [2*Y_W-1:0]          prod_q2;
    logic [Q2_W-1:0]           q2;
    logic [SUM_W-1:0]          mag_sum;
    logic signed [RES_W-1:0]   n_integral;

    assign en = !r_out_vld || o_res.ready;

    always_comb begin
        total = (TOT_W'(i_snap.simpson) <<< 3)
              + (TOT_W'(i_snap.tail) <<< 3) + TOT_W'(i_snap.tail)
              + (TOT_W'(i_snap.trap) <<< 3) + (TOT_W'(i_snap.trap) <<< 2);
        tot_abs = total[TOT_W-1] ? TOT_W'(-total) : TOT_W'(total);

        // floor(x/3) for a 32-bit x: multiply by ceil(2^33/3), keep the top.
        prod_a = (2*MAG_W-3)'(r2_mag[MAG_W-1:3]) * (2*MAG_W-3)'(RECIP3_33);

        // The remainder of the divide by 24 always fits in five bits.
        rem = r3_mag - (MAG_W'({r3_a, 4'b0}) + MAG_W'({r3_a, 3'b0}));

        prod_q2 = (2*Y_W)'(r4_bh[BH_W-1:3]) * (2*Y_W)'(RECIP3_19);
        q2      = prod_q2[2*Y_W-1:Y_W+1];
        mag_sum = SUM_W'(r4_ah) + SUM_W'(q2);
        if (r4_err) begin
            n_integral = '0;
        end else if (r4_neg) begin
            n_integral = -RES_W'(mag_sum);
        end else begin
            n_integral = RES_W'(mag_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r2_vld    <= i_snap_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r_out_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_err  <= i_snap.err;
            r2_neg  <= total[TOT_W-1];
            // The sums of any legal count stay below 2^31 in magnitude.
            r2_mag  <= tot_abs[MAG_W-1:0];
            r2_step <= i_snap.step;

            r3_err  <= r2_err;
            r3_neg  <= r2_neg;
            r3_mag  <= r2_mag;
            r3_a    <= prod_a[2*MAG_W-4:MAG_W+1];
            r3_step <= r2_step;

            r4_err  <= r3_err;
            r4_neg  <= r3_neg;
            r4_ah   <= AH_W'(r3_a) * AH_W'(r3_step);
            r4_bh   <= BH_W'(rem[4:0]) * BH_W'(r3_step);

            r_integral <= n_integral;
            r_status   <= r4_err ? STATUS_BAD : STATUS_OK;
        end
    end

    assign o_en           = en;
    assign o_res.valid    = r_out_vld;
    assign o_res.integral = r_integral;
    assign o_res.status   = r_status;

endmodule

FILE: rtl/simpson_integrator.sv
// Simpson integrator over a stream of equally spaced Q8.8 samples.
// Input channel i_smp carries one sample per beat; output channel o_res
// carries one result per finished integral: a signed 48-bit integral with
// 16 fraction bits and a status bit (1 marks an invalid sample count).
// The configuration port sets the sample count (index 0) and the step h
// (index 1, unsigned Q8.8); writing the count restarts the integral.
// The rule follows from the count: trapezoid for two, 3/8 for four,
// composite Simpson for odd counts, Simpson plus a 3/8 tail otherwise.
// A count outside 2..MAX_SAMPLES gives an error result for every sample.
// Throughput is one sample per cycle while the receiver does not stall;
// the weighted accumulate is combinational and registered on each beat.
// After the beat of the last sample the sums are registered, then the
// combined sum, the divide by 24 and the multiply by h go through a
// four-stage scaling pipeline. Reset restores count 2 and h = 51 and
// clears the sums. When the receiver stalls, the whole pipeline holds
// and i_smp.ready drops until the output register is taken.
module simpson_integrator import simp_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    simp_in_if.sink               i_smp,
    simp_out_if.source            o_res
);

    logic  en;
    logic  beat;
    logic  snap_vld;
    t_snap snap;

    assign i_smp.ready = en;
    assign beat        = i_smp.valid && en;

    simp_accum #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_beat     (beat),
        .i_sample   (i_smp.sample),
        .i_en       (en),
        .o_snap_vld (snap_vld),
        .o_snap     (snap)
    );

    simp_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_snap_vld (snap_vld),
        .i_snap     (snap),
        .o_en       (en),
        .o_res      (o_res)
    );

endmodule
